// File: hw/rtl/srrg_pkg.sv
package srrg_pkg;

	localparam int MAX_RBS = 100;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_DL     = 2'd1,
		OP_UL     = 2'd2,
		OP_TPC    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		AREA_UNSET  = 2'd0,
		AREA_EDGE   = 2'd1,
		AREA_CENTER = 2'd2
	} area_t;

	typedef enum logic [2:0] {
		REG_DL_BW     = 3'd0,
		REG_DL_COMMON = 3'd1,
		REG_DL_OFFSET = 3'd2,
		REG_DL_WIDTH  = 3'd3,
		REG_UL_LAYOUT = 3'd4,
		REG_Q_THRESH  = 3'd5,
		REG_AREA_SET  = 3'd6,
		REG_REPORT_ID = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  dl_bandwidth;
		logic [6:0]  dl_common_width;
		logic [6:0]  dl_edge_offset;
		logic [6:0]  dl_edge_width;
		logic [23:0] ul_layout;
		logic [5:0]  quality_threshold;
		logic [10:0] area_settings;
		logic [7:0]  accepted_report_id;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dl_bandwidth:       7'd25,
		dl_common_width:    7'd25,
		dl_edge_offset:     7'd0,
		dl_edge_width:      7'd0,
		ul_layout:          24'd25,
		quality_threshold:  6'd20,
		area_settings:      11'd1749,
		accepted_report_id: 8'd0
	};

	typedef struct packed {
		logic [15:0] id;
		area_t       area;
	} entry_t;

	// RBG size in blocks for a given downlink bandwidth
	function automatic logic [2:0] group_size(input logic [6:0] bw);
		logic [2:0] s;
		if (bw <= 7'd10) s = 3'd1;
		else if (bw <= 7'd26) s = 3'd2;
		else if (bw <= 7'd63) s = 3'd3;
		else s = 3'd4;
		return s;
	endfunction

	// Truncating divide by a group size of 1..4; thirds by reciprocal 43/128
	function automatic logic [6:0] div_gs(input logic [6:0] x, input logic [2:0] s);
		logic [12:0] p;
		logic [6:0]  r;
		p = 13'(x) * 13'd43;
		case (s)
			3'd1: r = x;
			3'd2: r = {1'b0, x[6:1]};
			3'd3: r = {1'b0, p[12:7]};
			default: r = {2'b0, x[6:2]};
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/srrg_band.sv
module srrg_band (
	input  logic               clk,
	input  srrg_pkg::cfg_t     cfg,
	input  logic [6:0]         group_index,
	input  logic               uplink,
	output logic               edge_hit
);
	import srrg_pkg::*;

	logic [2:0] gs;
	logic [6:0] dl_count_q;
	logic [7:0] dl_lo_q;
	logic [8:0] dl_hi_q;
	logic [8:0] ul_lo_q;
	logic [9:0] ul_hi_q;
	logic [7:0] dl_lo_c;
	logic [8:0] ul_lo_c;

	assign gs      = group_size(cfg.dl_bandwidth);
	assign dl_lo_c = 8'(div_gs(cfg.dl_common_width, gs)) + 8'(div_gs(cfg.dl_edge_offset, gs));
	assign ul_lo_c = 9'(cfg.ul_layout[7:0]) + 9'(cfg.ul_layout[15:8]);

	// Band limits are registered and follow the config registers in the next cycle
	always_ff @(posedge clk) begin
		dl_count_q <= div_gs(cfg.dl_bandwidth, gs);
		dl_lo_q    <= dl_lo_c;
		dl_hi_q    <= 9'(dl_lo_c) + 9'(div_gs(cfg.dl_edge_width, gs));
		ul_lo_q    <= ul_lo_c;
		ul_hi_q    <= 10'(ul_lo_c) + 10'(cfg.ul_layout[23:16]);
	end

	always_comb begin
		if (uplink) begin
			edge_hit = ({1'b0, group_index} < 8'(MAX_RBS)) &&
				(9'(group_index) >= ul_lo_q) && (10'(group_index) < ul_hi_q);
		end else begin
			edge_hit = (group_index < dl_count_q) &&
				(8'(group_index) >= dl_lo_q) && (9'(group_index) < dl_hi_q);
		end
	end

endmodule

// File: hw/rtl/strict_reuse_rbg_gate.sv
// Items that bypass the table pass from the input latch through the finishing
// state to the registered result; other items first run the terminal table
// scan, which reads one memory entry per cycle. One item at a time: the
// next input is taken once the result is in the output register.
// Reset: arst_n clears control state, the per-entry valid bits and all config
// registers to their defaults; table memory contents are masked until written.
module strict_reuse_rbg_gate #(
	parameter int MAX_UES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// ue_id[15:0], group_index[22:16], report_id[30:23], quality_value[36:31], zero pad
	input  logic [39:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// available[0], tpc_value[2:1], pa_update[3], pa_value[6:4], table_full[7]
	output logic [7:0]  m_tdata
);
	import srrg_pkg::*;

	localparam int IW = (MAX_UES > 1) ? $clog2(MAX_UES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;
	cfg_t   cfg_q;

	// latched item
	op_t         op_q;
	logic [15:0] id_q;
	logic [6:0]  grp_q;
	logic [5:0]  qual_q;
	logic        skip_q;

	// scan
	logic [IW:0]        iss_q;
	logic               cmp_vld_s1;
	logic [IW-1:0]      cmp_idx_s1;
	logic               ent_v_s1;
	entry_t             ent_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	area_t              hit_area_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic [MAX_UES-1:0] valid_q;

	entry_t tbl_mem [MAX_UES];

	logic        out_vld_q;
	logic [7:0]  out_data_q;

	logic          issuing;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          id_match;
	logic          edge_g;
	logic          fin_go;

	// result of the finishing step
	logic          wr_en;
	logic [IW-1:0] wr_slot;
	area_t         wr_area;
	area_t         want;
	logic          r_avail;
	logic [1:0]    r_tpc;
	logic          r_pa_upd;
	logic [2:0]    r_pa;
	logic          r_full;

	logic          ul_en;
	logic          wr_cfg;
	op_t           in_op;
	logic          in_skip;

	srrg_band u_band (
		.clk         (clk),
		.cfg         (cfg_q),
		.group_index (grp_q),
		.uplink      (op_q == OP_UL),
		.edge_hit    (edge_g)
	);

	assign pready   = 1'b1;
	assign wr_cfg   = psel & penable & pwrite;
	assign ul_en    = cfg_q.area_settings[10];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	assign in_op   = op_t'(s_tuser);
	assign in_skip = ((in_op == OP_REPORT) && (s_tdata[30:23] != cfg_q.accepted_report_id)) ||
		((in_op == OP_UL || in_op == OP_TPC) && !ul_en);

	assign issuing  = (state_q == ST_SCAN) && (iss_q < (IW+1)'(MAX_UES));
	assign rd_en    = issuing;
	assign rd_addr  = iss_q[IW-1:0];
	assign id_match = ent_v_s1 && (ent_s1.id == id_q);
	assign fin_go   = (state_q == ST_FIN) && (!out_vld_q || m_tready);

	always_comb begin
		case (paddr[4:2])
			REG_DL_BW:     prdata = 32'(cfg_q.dl_bandwidth);
			REG_DL_COMMON: prdata = 32'(cfg_q.dl_common_width);
			REG_DL_OFFSET: prdata = 32'(cfg_q.dl_edge_offset);
			REG_DL_WIDTH:  prdata = 32'(cfg_q.dl_edge_width);
			REG_UL_LAYOUT: prdata = 32'(cfg_q.ul_layout);
			REG_Q_THRESH:  prdata = 32'(cfg_q.quality_threshold);
			REG_AREA_SET:  prdata = 32'(cfg_q.area_settings);
			REG_REPORT_ID: prdata = 32'(cfg_q.accepted_report_id);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_slot  = hit_q ? hit_idx_q : free_idx_q;
		wr_area  = AREA_UNSET;
		want     = (qual_q < cfg_q.quality_threshold) ? AREA_EDGE : AREA_CENTER;
		r_avail  = 1'b0;
		r_tpc    = 2'd0;
		r_pa_upd = 1'b0;
		r_pa     = 3'd0;
		r_full   = 1'b0;
		if (skip_q) begin
			r_avail = (op_q == OP_UL);
			r_tpc   = (op_q == OP_TPC) ? 2'd1 : 2'd0;
		end else begin
			case (op_q)
				OP_REPORT: begin
					if (hit_q || free_q) begin
						wr_en   = 1'b1;
						wr_area = want;
						if ((hit_q ? hit_area_q : AREA_UNSET) != want) begin
							r_pa_upd = 1'b1;
							r_pa     = (want == AREA_EDGE) ? cfg_q.area_settings[6:4]
								: cfg_q.area_settings[9:7];
						end
					end else begin
						r_full = 1'b1;
					end
				end
				OP_DL, OP_UL: begin
					if (hit_q) begin
						r_avail = (edge_g == (hit_area_q == AREA_EDGE));
					end else begin
						r_avail = !edge_g;
						wr_en   = free_q;
						r_full  = !free_q;
					end
				end
				default: begin
					r_tpc = 2'd1;
					if (hit_q && hit_area_q == AREA_EDGE)
						r_tpc = cfg_q.area_settings[1:0];
					else if (hit_q && hit_area_q == AREA_CENTER)
						r_tpc = cfg_q.area_settings[3:2];
				end
			endcase
		end
	end

	// terminal table: one read port for the scan, one write in the finishing step
	always_ff @(posedge clk) begin
		if (fin_go && wr_en)
			tbl_mem[wr_slot] <= '{id: id_q, area: wr_area};
		if (rd_en)
			ent_s1 <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_q      <= CFG_RESET;
			valid_q    <= '0;
			out_vld_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			iss_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			skip_q     <= 1'b0;
		end else begin
			if (wr_cfg) begin
				case (paddr[4:2])
					REG_DL_BW:     cfg_q.dl_bandwidth       <= pwdata[6:0];
					REG_DL_COMMON: cfg_q.dl_common_width    <= pwdata[6:0];
					REG_DL_OFFSET: cfg_q.dl_edge_offset     <= pwdata[6:0];
					REG_DL_WIDTH:  cfg_q.dl_edge_width      <= pwdata[6:0];
					REG_UL_LAYOUT: cfg_q.ul_layout          <= pwdata[23:0];
					REG_Q_THRESH:  cfg_q.quality_threshold  <= pwdata[5:0];
					REG_AREA_SET:  cfg_q.area_settings      <= pwdata[10:0];
					REG_REPORT_ID: cfg_q.accepted_report_id <= pwdata[7:0];
					default: ;
				endcase
			end

			if (out_vld_q && m_tready && !fin_go)
				out_vld_q <= 1'b0;

			cmp_vld_s1 <= issuing;
			if (issuing) begin
				iss_q      <= iss_q + 1'b1;
				cmp_idx_s1 <= rd_addr;
				ent_v_s1   <= valid_q[rd_addr];
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= in_op;
						id_q    <= s_tdata[15:0];
						grp_q   <= s_tdata[22:16];
						qual_q  <= s_tdata[36:31];
						skip_q  <= in_skip;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						iss_q   <= '0;
						state_q <= in_skip ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmp_vld_s1) begin
						if (id_match) begin
							// first match wins; stop the scan
							hit_q      <= 1'b1;
							hit_idx_q  <= cmp_idx_s1;
							hit_area_q <= ent_s1.area;
							state_q    <= ST_FIN;
						end else begin
							if (!ent_v_s1 && !free_q) begin
								free_q     <= 1'b1;
								free_idx_q <= cmp_idx_s1;
							end
							if (cmp_idx_s1 == IW'(MAX_UES - 1))
								state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {r_full, r_pa, r_pa_upd, r_tpc, r_avail};
						if (wr_en)
							valid_q[wr_slot] <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import srrg_pkg::*;

	localparam int TBL_DEPTH   = 32;
	localparam int POOL_SIZE   = 40;
	localparam int STALL_LIMIT = 4000;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// result layout from the lowest bit up: available, tpc, pa_update, pa, table_full
	typedef struct packed {
		logic       table_full;
		logic [2:0] pa_value;
		logic       pa_update;
		logic [1:0] tpc_value;
		logic       available;
	} gate_rslt_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	// cell configuration and terminal table as the gate should hold them
	cfg_t        cell_cfg = CFG_RESET;
	bit          ue_valid [TBL_DEPTH];
	logic [15:0] ue_key [TBL_DEPTH];
	area_t       ue_zone [TBL_DEPTH];

	gate_rslt_t  answers_due [$];
	logic [15:0] ue_pool [POOL_SIZE];
	int          mismatches = 0;

	rx_mode_t    rx_mode = RX_ALWAYS;
	logic [7:0]  stall_pat = 8'h01;
	int          hold_req = 0;
	int          hold_left = 0;
	int          burst_left = 1;
	int          burst_max = 1;
	int          gap_max = 0;
	int          quiet = 0;

	strict_reuse_rbg_gate #(
		.MAX_UES(TBL_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int ue_find(logic [15:0] id);
		for (int i = 0; i < TBL_DEPTH; i++)
			if (ue_valid[i] && ue_key[i] == id) return i;
		return -1;
	endfunction

	function automatic int ue_add(logic [15:0] id);
		for (int i = 0; i < TBL_DEPTH; i++) begin
			if (!ue_valid[i]) begin
				ue_valid[i] = 1'b1;
				ue_key[i]   = id;
				ue_zone[i]  = AREA_UNSET;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int unsigned rbg_blocks(int unsigned bw);
		if (bw <= 10) return 1;
		if (bw <= 26) return 2;
		if (bw <= 63) return 3;
		return 4;
	endfunction

	function automatic bit dl_in_edge(int unsigned g);
		int unsigned s, cnt, lo, hi;
		s   = rbg_blocks(cell_cfg.dl_bandwidth);
		cnt = cell_cfg.dl_bandwidth / s;
		lo  = cell_cfg.dl_common_width / s + cell_cfg.dl_edge_offset / s;
		hi  = lo + cell_cfg.dl_edge_width / s;
		return g < cnt && g >= lo && g < hi;
	endfunction

	function automatic bit ul_in_edge(int unsigned g);
		int unsigned lo, hi;
		lo = int'(cell_cfg.ul_layout[7:0]) + int'(cell_cfg.ul_layout[15:8]);
		hi = lo + int'(cell_cfg.ul_layout[23:16]);
		return g < MAX_RBS && g >= lo && g < hi;
	endfunction

	function automatic gate_rslt_t gate_decision(op_t op, logic [15:0] id, logic [6:0] g,
			logic [7:0] rid, logic [5:0] q);
		gate_rslt_t r;
		int         k;
		bit         ul_on;
		bit         edge_grp;
		area_t      want;
		r     = '0;
		ul_on = cell_cfg.area_settings[10];
		case (op)
			OP_REPORT: begin
				if (rid == cell_cfg.accepted_report_id) begin
					k = ue_find(id);
					if (k < 0) begin
						k = ue_add(id);
						if (k < 0) r.table_full = 1'b1;
					end
					if (k >= 0) begin
						want = (q < cell_cfg.quality_threshold) ? AREA_EDGE : AREA_CENTER;
						if (ue_zone[k] != want) begin
							ue_zone[k]  = want;
							r.pa_update = 1'b1;
							r.pa_value  = (want == AREA_EDGE) ? cell_cfg.area_settings[6:4]
								: cell_cfg.area_settings[9:7];
						end
					end
				end
			end
			OP_DL, OP_UL: begin
				if (op == OP_UL && !ul_on) begin
					r.available = 1'b1;
				end else begin
					edge_grp = (op == OP_DL) ? dl_in_edge(g) : ul_in_edge(g);
					k = ue_find(id);
					if (k < 0) begin
						// unknown terminal: insert unset, grant non-edge groups only
						if (ue_add(id) < 0) r.table_full = 1'b1;
						r.available = !edge_grp;
					end else begin
						r.available = (edge_grp == (ue_zone[k] == AREA_EDGE));
					end
				end
			end
			default: begin
				r.tpc_value = 2'd1;
				if (ul_on) begin
					k = ue_find(id);
					if (k >= 0) begin
						if (ue_zone[k] == AREA_EDGE) r.tpc_value = cell_cfg.area_settings[1:0];
						else if (ue_zone[k] == AREA_CENTER)
							r.tpc_value = cell_cfg.area_settings[3:2];
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_DL_BW:     return 32'(cell_cfg.dl_bandwidth);
			REG_DL_COMMON: return 32'(cell_cfg.dl_common_width);
			REG_DL_OFFSET: return 32'(cell_cfg.dl_edge_offset);
			REG_DL_WIDTH:  return 32'(cell_cfg.dl_edge_width);
			REG_UL_LAYOUT: return 32'(cell_cfg.ul_layout);
			REG_Q_THRESH:  return 32'(cell_cfg.quality_threshold);
			REG_AREA_SET:  return 32'(cell_cfg.area_settings);
			default:       return 32'(cell_cfg.accepted_report_id);
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		gate_rslt_t got;
		gate_rslt_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = gate_rslt_t'(m_tdata);
			if (answers_due.size() == 0) begin
				$error("result transaction with none expected: %h", m_tdata);
				mismatches++;
			end else begin
				want = answers_due.pop_front();
				check_field("available", int'(want.available), int'(got.available));
				check_field("tpc_value", int'(want.tpc_value), int'(got.tpc_value));
				check_field("pa_update", int'(want.pa_update), int'(got.pa_update));
				check_field("pa_value", int'(want.pa_value), int'(got.pa_value));
				check_field("table_full", int'(want.table_full), int'(got.table_full));
			end
		end
	end

	// end the run if no transaction of any kind moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) quiet = 0;
		else quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: long hold-off on request, otherwise the current stall mode
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready = 1'b1;
				RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
				default: begin
					m_tready  = stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[7:1]};
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic apb_cycle(reg_idx_t idx, bit wr, logic [31:0] wval, output logic [31:0] rval);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wval;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rval = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic read_reg(reg_idx_t idx);
		logic [31:0] rval;
		apb_cycle(idx, 1'b0, 32'd0, rval);
		if (rval !== reg_value(idx)) begin
			$error("%s: expected %h, got %h", idx.name(), reg_value(idx), rval);
			mismatches++;
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		logic [31:0] unused;
		case (idx)
			REG_DL_BW:     cell_cfg.dl_bandwidth       = val[6:0];
			REG_DL_COMMON: cell_cfg.dl_common_width    = val[6:0];
			REG_DL_OFFSET: cell_cfg.dl_edge_offset     = val[6:0];
			REG_DL_WIDTH:  cell_cfg.dl_edge_width      = val[6:0];
			REG_UL_LAYOUT: cell_cfg.ul_layout          = val[23:0];
			REG_Q_THRESH:  cell_cfg.quality_threshold  = val[5:0];
			REG_AREA_SET:  cell_cfg.area_settings      = val[10:0];
			default:       cell_cfg.accepted_report_id = val[7:0];
		endcase
		apb_cycle(idx, 1'b1, val, unused);
		read_reg(idx);
	endtask

	task automatic set_cell(int bw, int cw, int eo, int ew, int ul, int qt, int as, int rid);
		write_reg(REG_DL_BW, bw);
		write_reg(REG_DL_COMMON, cw);
		write_reg(REG_DL_OFFSET, eo);
		write_reg(REG_DL_WIDTH, ew);
		write_reg(REG_UL_LAYOUT, ul);
		write_reg(REG_Q_THRESH, qt);
		write_reg(REG_AREA_SET, as);
		write_reg(REG_REPORT_ID, rid);
	endtask

	task automatic set_idling(rx_mode_t rm, int bmax, int gmax);
		rx_mode    = rm;
		stall_pat  = 8'($urandom) | 8'h01;
		burst_max  = bmax;
		gap_max    = gmax;
		burst_left = 1;
	endtask

	task automatic send_item(op_t op, logic [15:0] id, logic [6:0] g, logic [7:0] rid,
			logic [5:0] q);
		int gap;
		s_tuser  = op;
		s_tdata  = {3'b000, q, rid, g, id};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		answers_due.push_back(gate_decision(op, id, g, rid, q));
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic random_item();
		op_t         op;
		logic [15:0] id;
		logic [6:0]  g;
		logic [7:0]  rid;
		logic [5:0]  q;
		op  = op_t'($urandom_range(0, 3));
		id  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ue_pool[$urandom_range(0, POOL_SIZE - 1)];
		g   = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
		rid = ($urandom_range(0, 6) == 0) ? 8'($urandom) : cell_cfg.accepted_report_id;
		q   = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 34));
		send_item(op, id, g, rid, q);
	endtask

	// drop valid, wait for every expected result, then let the scan finish
	task automatic settle();
		s_tvalid = 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (TBL_DEPTH + 4) @(negedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_register_defaults();
		for (int i = 0; i < 8; i++) read_reg(reg_idx_t'(i));
	endtask

	task automatic test_directed();
		// dl edge groups 6..8 of 16, ul edge blocks 12..16
		set_cell(50, 15, 3, 9, 32'({8'd5, 8'd2, 8'd10}), 20, 1854, 'hA5);
		set_idling(RX_ALWAYS, 1, 2);
		send_item(OP_TPC, 16'h1234, 7'd0, 8'h00, 6'd0);
		send_item(OP_DL, 16'h1234, 7'd7, 8'h00, 6'd0);
		send_item(OP_DL, 16'h1234, 7'd2, 8'h00, 6'd0);
		send_item(OP_REPORT, 16'h1234, 7'd0, 8'h5A, 6'd0);
		send_item(OP_REPORT, 16'h1234, 7'd0, 8'hA5, 6'd0);
		send_item(OP_REPORT, 16'h1234, 7'd0, 8'hA5, 6'd19);
		send_item(OP_REPORT, 16'h1234, 7'd0, 8'hA5, 6'd20);
		send_item(OP_DL, 16'h1234, 7'd8, 8'h00, 6'd0);
		send_item(OP_TPC, 16'h1234, 7'd0, 8'h00, 6'd0);
		send_item(OP_REPORT, 16'hFFFF, 7'd0, 8'hA5, 6'd63);
		send_item(OP_REPORT, 16'h0000, 7'd0, 8'hA5, 6'd1);
		send_item(OP_DL, 16'h0000, 7'd6, 8'h00, 6'd0);
		send_item(OP_DL, 16'h0000, 7'd16, 8'h00, 6'd0);
		send_item(OP_DL, 16'h0000, 7'd127, 8'hFF, 6'd63);
		send_item(OP_UL, 16'h0000, 7'd12, 8'h00, 6'd0);
		send_item(OP_UL, 16'h0000, 7'd17, 8'h00, 6'd0);
		send_item(OP_UL, 16'hABCD, 7'd16, 8'h00, 6'd0);
		send_item(OP_TPC, 16'h0000, 7'd0, 8'h00, 6'd0);
		send_item(OP_UL, 16'hFFFF, 7'd99, 8'h00, 6'd0);
		settle();
	endtask

	task automatic test_uplink_disabled();
		write_reg(REG_AREA_SET, 1854 & ~1024);
		send_item(OP_UL, 16'h7777, 7'd12, 8'h00, 6'd0);
		send_item(OP_TPC, 16'h0000, 7'd0, 8'h00, 6'd0);
		send_item(OP_DL, 16'h7777, 7'd0, 8'h00, 6'd0);
		settle();
	endtask

	task automatic test_oversized_bands();
		// the uplink upper limit runs past the map and must clip, not wrap; the downlink edge ends at the map's end
		set_cell(100, 0, 0, 100, 32'({8'd255, 8'd60, 8'd0}), 20, 1854, 'hA5);
		send_item(OP_DL, 16'h0000, 7'd24, 8'h00, 6'd0);
		send_item(OP_DL, 16'h0000, 7'd25, 8'h00, 6'd0);
		send_item(OP_UL, 16'h0000, 7'd99, 8'h00, 6'd0);
		send_item(OP_UL, 16'h0000, 7'd100, 8'h00, 6'd0);
		settle();
	endtask

	task automatic test_backpressure();
		set_idling(RX_ALWAYS, 16, 0);
		hold_req = 300;
		repeat (12) random_item();
		settle();
	endtask

	task automatic run_random(int n, rx_mode_t rm, int bmax, int gmax);
		set_idling(rm, bmax, gmax);
		repeat (n) random_item();
		settle();
	endtask

	task automatic test_random_phases();
		set_cell(15, 0, 0, 0, 0, 0, 0, 0);
		run_random(200, RX_RANDOM, 8, 5);
		set_cell(100, 100, 100, 100, 'hFFFFFF, 34, 2047, 255);
		run_random(200, RX_PATTERN, 4, 3);
		set_cell($urandom_range(15, 100), $urandom_range(0, 100), $urandom_range(0, 100),
			$urandom_range(0, 100),
			32'({8'($urandom_range(0, 100)), 8'($urandom_range(0, 100)),
				8'($urandom_range(0, 100))}),
			$urandom_range(0, 34), $urandom_range(0, 2047), $urandom_range(0, 255));
		run_random(200, RX_ALWAYS, 1, 0);
		set_cell($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 127), $urandom & 'hFFFFFF, $urandom_range(0, 63),
			$urandom_range(0, 2047), $urandom_range(0, 255));
		run_random(200, RX_RANDOM, 3, 10);
		set_cell(10, 3, 2, 4, 32'({8'd100, 8'd0, 8'd0}), 17, 1749, 'h3C);
		run_random(200, RX_PATTERN, 20, 2);
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_REPORT;
		foreach (ue_valid[i]) begin
			ue_valid[i] = 1'b0;
			ue_key[i]   = '0;
			ue_zone[i]  = AREA_UNSET;
		end
		ue_pool[0] = 16'h0000;
		ue_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++) ue_pool[i] = 16'($urandom);
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_register_defaults();
		test_directed();
		test_uplink_disabled();
		test_oversized_bands();
		test_backpressure();
		test_random_phases();

		settle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
